### hw/rtl/set_assoc_cache_tag_replacement_macros.svh
// Assertion macros for the cache tag store
`ifndef SET_ASSOC_CACHE_TAG_REPLACEMENT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_REPLACEMENT_MACROS_SVH

// Same-cycle implication on clk_i, off while in reset
`define SAC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while in reset
`define SAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sac_pkg.sv
// Shared constants, codes and control types of the cache tag store
package sac_pkg;

  localparam int unsigned MAX_WAYS_DEF    = 64;
  localparam int unsigned MAX_SETS_DEF    = 1024;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned TAG_W    = 64;
  localparam int unsigned TOT_W    = 32;
  localparam int unsigned WAYO_W   = 6;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned OUT_W    = 72;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd3;

  localparam logic [1:0] POL_RR  = 2'd0;
  localparam logic [1:0] POL_LRU = 2'd1;
  localparam logic [1:0] POL_LFU = 2'd2;

  localparam logic [3:0] IB_RST = 4'd6;
  localparam logic [4:0] OB_RST = 5'd6;
  localparam logic [2:0] WL_RST = 3'd2;
  localparam logic [4:0] OB_MAX = 5'd16;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic upd;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic last_rd;
    logic out_free;
  } status_t;

endpackage

### hw/rtl/sac_ram.sv
// Generic single write port RAM with registered read
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### hw/rtl/sac_ctrl.sv
// Access sequencer of the cache tag store
module sac_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sac_pkg::status_t st_i,
  output sac_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SCAN     = 3'd2;
  localparam logic [2:0] S_SCAN_END = 3'd3;
  localparam logic [2:0] S_DECIDE   = 3'd4;
  localparam logic [2:0] S_UPD      = 3'd5;
  localparam logic [2:0] S_UPD_END  = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (st_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.rd = 1'b1;
        if (st_i.last_rd) state_d = S_SCAN_END;
      end
      S_SCAN_END: state_d = S_DECIDE;
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_UPD;
      end
      S_UPD: begin
        cmd_o.rd  = 1'b1;
        cmd_o.upd = 1'b1;
        if (st_i.last_rd) state_d = S_UPD_END;
      end
      S_UPD_END: state_d = S_DONE;
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

endmodule

### hw/rtl/sac_dp.sv
// Tag, replacement and counter datapath of the cache tag store
module sac_dp #(
  parameter int unsigned MAX_WAYS    = sac_pkg::MAX_WAYS_DEF,
  parameter int unsigned MAX_SETS    = sac_pkg::MAX_SETS_DEF,
  parameter int unsigned COUNT_WIDTH = sac_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sac_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic [sac_pkg::ADDR_W-1:0]    addr_i,
  input  sac_pkg::cmd_t                 cmd_i,
  output sac_pkg::status_t              st_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [sac_pkg::OUT_W-1:0]     out_data_o
);

  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned LINES  = MAX_SETS * MAX_WAYS;
  localparam int unsigned LA_W   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned IB_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int unsigned WL_MAX = $clog2(MAX_WAYS + 1) - 1;
  localparam int unsigned TW     = sac_pkg::TAG_W;
  localparam int unsigned RW     = sac_pkg::RANK_W;
  localparam int unsigned ENT_W  = 1 + TW + COUNT_WIDTH + RW;

  // configuration
  logic [1:0] pol_q;
  logic [3:0] ib_q;
  logic [4:0] ob_q;
  logic [2:0] wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q <= sac_pkg::POL_LRU;
      ib_q  <= sac_pkg::IB_RST;
      ob_q  <= sac_pkg::OB_RST;
      wl_q  <= sac_pkg::WL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sac_pkg::CFG_POLICY: pol_q <= cfg_data_i[1:0];
        sac_pkg::CFG_INDEX:  ib_q  <= cfg_data_i[3:0];
        sac_pkg::CFG_OFFSET: ob_q  <= cfg_data_i[4:0];
        sac_pkg::CFG_WAYS:   wl_q  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [3:0]       ib_c;
  logic [4:0]       ob_c;
  logic [2:0]       wl_c;
  logic [TW-1:0]    shifted, set_full, tag_d;
  logic [SET_W-1:0] set_d;
  logic [WAY_W-1:0] lastw_d;

  always_comb begin
    ib_c     = ({1'b0, ib_q} > 5'(IB_MAX)) ? 4'(IB_MAX) : ib_q;
    ob_c     = (ob_q > sac_pkg::OB_MAX) ? sac_pkg::OB_MAX : ob_q;
    wl_c     = ({1'b0, wl_q} > 4'(WL_MAX)) ? 3'(WL_MAX) : wl_q;
    shifted  = addr_i >> ob_c;
    set_full = shifted & ~({TW{1'b1}} << ib_c);
    set_d    = set_full[SET_W-1:0];
    tag_d    = addr_i >> (6'(ib_c) + 6'(ob_c));
    lastw_d  = WAY_W'((7'd1 << wl_c) - 7'd1);
  end

  logic [SET_W-1:0] set_q;
  logic [TW-1:0]    tag_q;
  logic [WAY_W-1:0] lastw_q;
  logic             dm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q   <= set_d;
      tag_q   <= tag_d;
      lastw_q <= lastw_d;
      dm_q    <= (wl_c == 3'd0);
    end
  end

  // way walk and clearing sweep
  logic [WAY_W-1:0] rd_idx_q, chk_idx_q, clr_way_q;
  logic [SET_W-1:0] clr_set_q;
  logic             chk_v_q, chk_upd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      chk_v_q   <= 1'b0;
      chk_upd_q <= 1'b0;
      clr_way_q <= '0;
      clr_set_q <= '0;
    end else begin
      chk_v_q   <= cmd_i.rd;
      chk_upd_q <= cmd_i.upd;
      if (cmd_i.load || cmd_i.decide) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (cmd_i.clr) begin
        if (clr_way_q == WAY_W'(MAX_WAYS - 1)) begin
          clr_way_q <= '0;
          clr_set_q <= (clr_set_q == SET_W'(MAX_SETS - 1)) ? '0 : clr_set_q + 1'b1;
        end else begin
          clr_way_q <= clr_way_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q <= rd_idx_q;
  end

  assign st_o.last_rd  = (rd_idx_q == lastw_q);
  assign st_o.clr_last = (clr_way_q == WAY_W'(MAX_WAYS - 1)) &&
                         (clr_set_q == SET_W'(MAX_SETS - 1));

  // memories
  logic             ent_we;
  logic [LA_W-1:0]  ent_waddr, ent_raddr;
  logic [ENT_W-1:0] ent_wdata, ent_rdata;
  logic             rr_we;
  logic [SET_W-1:0] rr_waddr;
  logic [WAY_W-1:0] rr_wdata, rr_rdata;

  function automatic logic [LA_W-1:0] line_addr(logic [SET_W-1:0] s, logic [WAY_W-1:0] w);
    line_addr = LA_W'(s) * LA_W'(MAX_WAYS) + LA_W'(w);
  endfunction

  sac_ram #(.WIDTH(ENT_W), .DEPTH(LINES)) u_ent_ram (
    .clk_i  (clk_i),
    .we_i   (ent_we),
    .waddr_i(ent_waddr),
    .wdata_i(ent_wdata),
    .raddr_i(ent_raddr),
    .rdata_o(ent_rdata)
  );

  sac_ram #(.WIDTH(WAY_W), .DEPTH(MAX_SETS)) u_rr_ram (
    .clk_i  (clk_i),
    .we_i   (rr_we),
    .waddr_i(rr_waddr),
    .wdata_i(rr_wdata),
    .raddr_i(set_q),
    .rdata_o(rr_rdata)
  );

  assign ent_raddr = line_addr(set_q, rd_idx_q);

  logic                   e_valid;
  logic [TW-1:0]          e_tag;
  logic [COUNT_WIDTH-1:0] e_cnt;
  logic [RW-1:0]          e_rank;

  assign e_valid = ent_rdata[0];
  assign e_tag   = ent_rdata[TW:1];
  assign e_cnt   = ent_rdata[TW+COUNT_WIDTH:TW+1];
  assign e_rank  = ent_rdata[ENT_W-1 -: RW];

  // set scan
  logic                   hit_q, inv_q;
  logic [WAY_W-1:0]       hw_q, iw_q, minw_q, maxw_q, w_q;
  logic [RW-1:0]          hr_q, ir_q, maxr_q, r_q;
  logic [COUNT_WIDTH-1:0] minc_q;
  logic                   first;

  assign first = (chk_idx_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (chk_v_q && !chk_upd_q) begin
      if (!hit_q && e_valid && (e_tag == tag_q)) begin
        hit_q <= 1'b1;
        hw_q  <= chk_idx_q;
        hr_q  <= e_rank;
      end
      if (!inv_q && !e_valid) begin
        inv_q <= 1'b1;
        iw_q  <= chk_idx_q;
        ir_q  <= e_rank;
      end
      if (first || (e_cnt < minc_q)) begin
        minc_q <= e_cnt;
        minw_q <= chk_idx_q;
      end
      if (first || (e_rank > maxr_q)) begin
        maxr_q <= e_rank;
        maxw_q <= chk_idx_q;
      end
    end
  end

  // victim choice
  logic [WAY_W-1:0] w_d, rr_w;
  logic [RW-1:0]    r_d;
  logic             rr_adv;

  always_comb begin
    rr_w   = rr_rdata & lastw_q;
    rr_adv = 1'b0;
    if (hit_q) begin
      w_d = hw_q;
      r_d = hr_q;
    end else if (pol_q == sac_pkg::POL_LFU) begin
      w_d = minw_q;
      r_d = '0;
    end else if (inv_q) begin
      w_d = iw_q;
      r_d = ir_q;
    end else if (dm_q) begin
      w_d = '0;
      r_d = maxr_q;
    end else if (pol_q == sac_pkg::POL_LRU) begin
      w_d = maxw_q;
      r_d = maxr_q;
    end else begin
      w_d    = rr_w;
      r_d    = '0;
      rr_adv = 1'b1;
    end
  end

  logic [sac_pkg::TOT_W-1:0] hitc_q, missc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hitc_q  <= '0;
      missc_q <= '0;
    end else if (cmd_i.decide) begin
      if (hit_q) begin
        if (!(&hitc_q)) hitc_q <= hitc_q + 1'b1;
      end else begin
        if (!(&missc_q)) missc_q <= missc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      w_q <= w_d;
      r_q <= r_d;
    end
  end

  // write-back
  logic [ENT_W-1:0]       upd_data;
  logic                   n_valid;
  logic [TW-1:0]          n_tag;
  logic [COUNT_WIDTH-1:0] n_cnt;
  logic [RW-1:0]          n_rank;

  always_comb begin
    n_valid = e_valid;
    n_tag   = e_tag;
    n_cnt   = e_cnt;
    n_rank  = e_rank;
    if (chk_idx_q == w_q) begin
      if (hit_q) begin
        if (!(&e_cnt)) n_cnt = e_cnt + 1'b1;
      end else begin
        n_valid = 1'b1;
        n_tag   = tag_q;
        n_cnt   = COUNT_WIDTH'(1);
      end
      if (pol_q == sac_pkg::POL_LRU) n_rank = '0;
    end else if ((pol_q == sac_pkg::POL_LRU) && (e_rank < r_q)) begin
      n_rank = e_rank + 1'b1;
    end
    upd_data = {n_rank, n_cnt, n_tag, n_valid};
  end

  always_comb begin
    if (cmd_i.clr) begin
      ent_we    = 1'b1;
      ent_waddr = line_addr(clr_set_q, clr_way_q);
      ent_wdata = {RW'(clr_way_q), {(COUNT_WIDTH + TW + 1){1'b0}}};
      rr_we     = (clr_way_q == '0);
      rr_waddr  = clr_set_q;
      rr_wdata  = '0;
    end else begin
      ent_we    = chk_v_q && chk_upd_q;
      ent_waddr = line_addr(set_q, chk_idx_q);
      ent_wdata = upd_data;
      rr_we     = cmd_i.decide && rr_adv;
      rr_waddr  = set_q;
      rr_wdata  = (rr_w + 1'b1) & lastw_q;
    end
  end

  // result register
  logic                      out_v_q;
  logic [sac_pkg::OUT_W-1:0] out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= {1'b0, missc_q, hitc_q, sac_pkg::WAYO_W'(w_q), hit_q};
    end
  end

  assign st_o.out_free = !out_v_q || out_ready_i;
  assign out_valid_o   = out_v_q;
  assign out_data_o    = out_q;

endmodule

### hw/rtl/set_assoc_cache_tag_replacement.sv
// Set-associative cache tag store with round robin, LRU and LFU replacement.
// Accesses are handled one at a time: s_axis_tready_o is high only while idle, and the set
// is walked twice through the line store, once to compare and once to write back tags,
// counts and ranks, before the result is registered and input opens again.
// Reset: asynchronous, active low; a clearing sweep over all MAX_SETS * MAX_WAYS lines then
// initialises the line store and pointers, with s_axis_tready_o held low throughout.
`include "set_assoc_cache_tag_replacement_macros.svh"
module set_assoc_cache_tag_replacement #(
  parameter int unsigned MAX_WAYS    = sac_pkg::MAX_WAYS_DEF,
  parameter int unsigned MAX_SETS    = sac_pkg::MAX_SETS_DEF,
  parameter int unsigned COUNT_WIDTH = sac_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sac_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sac_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [sac_pkg::ADDR_W-1:0]    s_axis_tdata_i,  // address
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [sac_pkg::OUT_W-1:0]     m_axis_tdata_o   // hit, way, hit_total, miss_total
);

  sac_pkg::cmd_t    cmd;
  sac_pkg::status_t st;

  sac_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .st_i      (st),
    .cmd_o     (cmd)
  );

  sac_dp #(
    .MAX_WAYS   (MAX_WAYS),
    .MAX_SETS   (MAX_SETS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .addr_i     (s_axis_tdata_i),
    .cmd_i      (cmd),
    .st_o       (st),
    .out_ready_i(m_axis_tready_i),
    .out_valid_o(m_axis_tvalid_o),
    .out_data_o (m_axis_tdata_o)
  );

  `SAC_ASSERT_NEXT(a_busy_after_beat, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "accepted beat did not close input")
  `SAC_ASSERT_NEXT(a_finish_shows, cmd.finish, m_axis_tvalid_o, "finished access not presented")
  `SAC_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.clr, cmd.load, cmd.rd, cmd.decide, cmd.finish}), "overlapping commands")
  `SAC_ASSERT_IMPL(a_clr_no_input, cmd.clr, !s_axis_tready_o, "input open during clearing sweep")

endmodule

### test/set_assoc_cache_tag_replacement_tb.sv
// Testbench for the cache tag store: predicts hit, way and running totals per address beat
`timescale 1ns / 100ps
module set_assoc_cache_tag_replacement_tb;
  import sac_pkg::*;

  localparam int unsigned NWAYS = MAX_WAYS_DEF;
  localparam int unsigned NSETS = MAX_SETS_DEF;
  localparam int unsigned NLINES = NWAYS * NSETS;
  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [TOT_W-1:0]  miss_total;
    logic [TOT_W-1:0]  hit_total;
    logic [WAYO_W-1:0] way;
    logic              hit;
  } lookup_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [ADDR_W-1:0]    s_axis_tdata_i = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata_o;

  set_assoc_cache_tag_replacement DUT (.*);

  always #4 clk_i = ~clk_i;

  // cache shadow
  logic [1:0]        pol_q;
  logic [3:0]        ib_q;
  logic [4:0]        ob_q;
  logic [2:0]        wl_q;
  bit                shadow_valid [NLINES];
  logic [TAG_W-1:0]  shadow_tag   [NLINES];
  logic [COUNT_WIDTH_DEF-1:0] shadow_uses [NLINES];
  logic [RANK_W-1:0] shadow_rank  [NLINES];
  logic [WAYO_W-1:0] shadow_rr    [NSETS];
  logic [TOT_W-1:0]  hits_seen, misses_seen;

  lookup_t     lookups_due[$];
  logic [63:0] addr_pending[$];
  int unsigned addrs_queued = 0, addrs_taken = 0, lookups_taken = 0;
  int unsigned fail_cnt = 0;

  function automatic int unsigned eff_ib();
    return (ib_q > 4'd10) ? 10 : ib_q;
  endfunction
  function automatic int unsigned eff_ob();
    return (ob_q > OB_MAX) ? 16 : ob_q;
  endfunction
  function automatic int unsigned eff_wl();
    return (wl_q > 3'd6) ? 6 : wl_q;
  endfunction

  function automatic void bump_recency(int unsigned base, int unsigned nw, int unsigned w);
    logic [RANK_W-1:0] r;
    r = shadow_rank[base + w];
    for (int unsigned i = 0; i < nw; i++)
      if (i != w && shadow_rank[base + i] < r)
        shadow_rank[base + i] = shadow_rank[base + i] + 1'b1;
    shadow_rank[base + w] = '0;
  endfunction

  function automatic lookup_t cache_lookup(logic [63:0] addr);
    lookup_t res;
    int unsigned ib, ob, nw, set, base, w;
    logic [63:0] tag;
    bit hit, found;
    ib = eff_ib(); ob = eff_ob(); nw = 1 << eff_wl();
    set = 32'((addr >> ob) & ((64'd1 << ib) - 1));
    tag = addr >> (ib + ob);
    base = set * NWAYS;
    hit = 0; w = 0; found = 0;
    for (int unsigned i = 0; i < nw; i++)
      if (!hit && shadow_valid[base + i] && shadow_tag[base + i] == tag) begin
        hit = 1; w = i;
      end
    if (hit) begin
      if (hits_seen != '1) hits_seen++;
      if (shadow_uses[base + w] != '1) shadow_uses[base + w]++;
      if (pol_q == POL_LRU) bump_recency(base, nw, w);
    end else begin
      if (misses_seen != '1) misses_seen++;
      if (pol_q == POL_LFU) begin
        for (int unsigned i = 1; i < nw; i++)
          if (shadow_uses[base + i] < shadow_uses[base + w]) w = i;
      end else begin
        for (int unsigned i = 0; i < nw; i++)
          if (!found && !shadow_valid[base + i]) begin
            w = i; found = 1;
          end
        if (!found && nw > 1) begin
          if (pol_q == POL_LRU) begin
            for (int unsigned i = 1; i < nw; i++)
              if (shadow_rank[base + i] > shadow_rank[base + w]) w = i;
          end else begin
            w = shadow_rr[set] & (nw - 1);
            shadow_rr[set] = WAYO_W'((w + 1) & (nw - 1));
          end
        end
      end
      shadow_valid[base + w] = 1;
      shadow_tag[base + w] = tag;
      shadow_uses[base + w] = 1;
      if (pol_q == POL_LRU) bump_recency(base, nw, w);
    end
    res.hit = hit;
    res.way = WAYO_W'(w);
    res.hit_total = hits_seen;
    res.miss_total = misses_seen;
    return res;
  endfunction

  // mostly a small pool of tags over a few sets so that lines get reused and evicted
  function automatic logic [63:0] pick_addr();
    int unsigned ib, ob, nw;
    logic [63:0] a, tag, set, offs;
    ib = eff_ib(); ob = eff_ob(); nw = 1 << eff_wl();
    if ($urandom_range(0, 9) < 2) return {$urandom, $urandom};
    tag = 64'($urandom_range(0, 2 * nw));
    if ($urandom_range(0, 7) == 0) tag = tag | ({$urandom, $urandom} << 20);
    set = 64'($urandom_range(0, 3));
    offs = {$urandom, $urandom} & ((64'd1 << ob) - 1);
    a = (tag << (ib + ob)) | ((set & ((64'd1 << ib) - 1)) << ob) | offs;
    return a;
  endfunction

  // input side: predict at each accepted beat
  logic in_beat = 1'b0;
  always @(posedge clk_i) begin
    in_beat <= s_axis_tvalid_i && s_axis_tready_o;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      lookups_due.push_back(cache_lookup(s_axis_tdata_i));
      addrs_taken++;
    end
  end

  int unsigned burst_left = 0, gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (in_beat || !s_axis_tvalid_i)) begin
      if (gap_left > 0) begin
        s_axis_tvalid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (addr_pending.size() > 0) begin
        s_axis_tdata_i <= addr_pending.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 160);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  int unsigned rx_mode = 0, rx_age = 0, hold_left = 0;
  bit long_hold_done = 0;
  always @(negedge clk_i) begin
    rx_age <= rx_age + 1;
    if (rx_age % 96 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && lookups_taken == 40) begin
      m_axis_tready_i <= 1'b0;
      hold_left <= 600;
      long_hold_done <= 1;
    end else begin
      case (rx_mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 7) != 0);
        default: m_axis_tready_i <= (rx_age % 5 < 2);
      endcase
    end
  end

  always @(posedge clk_i) begin
    lookup_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      lookups_taken++;
      got = m_axis_tdata_o[$bits(lookup_t)-1:0];
      if (lookups_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = lookups_due.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display({"lookup %0d: exp hit %b way %0d hits %0d misses %0d, ",
                      "got hit %b way %0d hits %0d misses %0d"},
                     lookups_taken, want.hit, want.way, want.hit_total, want.miss_total,
                     got.hit, got.way, got.hit_total, got.miss_total);
        end
      end
    end
  end

  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    case (idx)
      CFG_POLICY: pol_q = val[1:0];
      CFG_INDEX:  ib_q = val[3:0];
      CFG_OFFSET: ob_q = val[4:0];
      default:    wl_q = val[2:0];
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic queue_addr(input logic [63:0] a);
    addr_pending.push_back(a);
    addrs_queued++;
  endtask

  task automatic drain();
    while (addrs_taken != addrs_queued || lookups_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [1:0] p, input logic [3:0] ib, input logic [4:0] ob,
                           input logic [2:0] wl, input int unsigned n);
    write_reg(CFG_POLICY, p);
    write_reg(CFG_INDEX, ib);
    write_reg(CFG_OFFSET, ob);
    write_reg(CFG_WAYS, wl);
    for (int unsigned i = 0; i < n; i++) queue_addr(pick_addr());
    drain();
  endtask

  initial begin
    pol_q = POL_LRU; ib_q = IB_RST; ob_q = OB_RST; wl_q = WL_RST;
    hits_seen = '0; misses_seen = '0;
    for (int unsigned i = 0; i < NLINES; i++) begin
      shadow_valid[i] = 0;
      shadow_tag[i] = '0;
      shadow_uses[i] = '0;
      shadow_rank[i] = RANK_W'(i % NWAYS);
    end
    for (int unsigned i = 0; i < NSETS; i++) shadow_rr[i] = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // address extremes, repeats for hits, five tags into one set to force an LRU eviction
    queue_addr(64'h0);
    queue_addr(64'h0);
    queue_addr('1);
    queue_addr('1);
    queue_addr(64'h8000_0000_0000_0000);
    queue_addr(64'h0000_0000_0000_003F);
    for (int unsigned t = 1; t <= 5; t++) queue_addr(64'(t) << 12);
    queue_addr(64'h1000);
    queue_addr(64'h5000);
    queue_addr(64'h0000_0000_0000_0FC0);
    drain();

    run_phase(POL_RR, 4'd0, 5'd0, 3'd0, 60);
    run_phase(POL_RR, 4'd3, 5'd4, 3'd3, 80);
    run_phase(POL_LFU, 4'd10, 5'd16, 3'd6, 50);
    run_phase(2'd3, 4'd15, 5'd31, 3'd7, 40);
    run_phase(POL_LFU, 4'd2, 5'd5, 3'd1, 80);
    run_phase(POL_LRU, 4'd0, 5'd6, 3'd6, 60);
    run_phase(POL_RR, 4'd1, 5'd2, 3'd2, 70);
    run_phase(POL_LRU, 4'd6, 5'd6, 3'd2, 60);

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
